// ----- rtl/sme_pkg.sv -----
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types, opcodes and status codes for the stack machine executor.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int DATA_W          = 32;
    localparam int OP_W            = 4;
    localparam int STATUS_W        = 3;
    localparam int DEPTH_W         = 6;
    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [OP_W-1:0] OP_PUSH   = 4'd0;
    localparam logic [OP_W-1:0] OP_POP    = 4'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 4'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 4'd3;
    localparam logic [OP_W-1:0] OP_DUP    = 4'd4;
    localparam logic [OP_W-1:0] OP_SWAP   = 4'd5;
    localparam logic [OP_W-1:0] OP_ASSERT = 4'd6;
    localparam logic [OP_W-1:0] OP_ADD    = 4'd7;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL    = 4'd9;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd10;
    localparam logic [OP_W-1:0] OP_MOD    = 4'd11;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ASSERT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd4;

    // address select for the RAM read port
    typedef enum logic [1:0] {
        RA_TOP,
        RA_NEXT,
        RA_DUMP
    } raddr_sel_t;

    // write data select
    typedef enum logic [1:0] {
        WD_OPERAND,
        WD_A,
        WD_B,
        WD_RESULT
    } wdata_sel_t;

    // write address select
    typedef enum logic [1:0] {
        WA_COUNT,
        WA_TOP,
        WA_NEXT
    } waddr_sel_t;

    // result source
    typedef enum logic [1:0] {
        RS_TOP,
        RS_DUMP,
        RS_ZERO
    } rsel_t;

    typedef struct packed {
        raddr_sel_t              raddr_sel;
        logic                    dump_load;
        logic                    dump_dec;
        logic                    ld_a;
        logic                    ld_b;
        logic                    ld_top;
        logic                    we;
        waddr_sel_t              waddr_sel;
        wdata_sel_t              wdata_sel;
        logic                    cnt_inc;
        logic                    cnt_dec;
        logic                    cnt_clr;
        logic                    alu_go;
        logic                    div_go;
        logic                    emit;
        rsel_t                   rsel;
        logic [STATUS_W-1:0]     status;
        logic                    last;
    } sme_cmd_t;

    typedef struct packed {
        logic empty;
        logic one;
        logic full;
        logic dump_last;
        logic div_done;
        logic b_zero;
        logic div_ovf;
        logic assert_eq;
    } sme_stat_t;

endpackage

// ----- rtl/sme_ram.sv -----
// ----------------------------------------------------------------------------
// sme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sme_div.sv -----
// ----------------------------------------------------------------------------
// sme_div
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module sme_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic signed [sme_pkg::DATA_W-1:0] dividend,
    input  logic signed [sme_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [sme_pkg::DATA_W-1:0] quotient,
    output logic [sme_pkg::DATA_W-1:0] remainder
);
    import sme_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic              qneg_reg, qneg_next;
    logic              rneg_reg, rneg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg, q_reg[DATA_W-1]};
        trial     = shifted - {1'b0, d_reg};
        if (go)
        begin
            q_next    = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            d_next    = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            r_next    = '0;
            qneg_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rneg_next = dividend[DATA_W-1];
            cnt_next  = CNT_W'(DATA_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                r_next = trial[DATA_W-1:0];
                q_next = {q_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[DATA_W-1:0];
                q_next = {q_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? (~q_reg + 1'b1) : q_reg;
    assign remainder = rneg_reg ? (~r_reg + 1'b1) : r_reg;

endmodule

// ----- rtl/sme_datapath.sv -----
// ----------------------------------------------------------------------------
// sme_datapath
// Stack RAM, depth counter, operand registers, ALU and divider.
// ----------------------------------------------------------------------------
module sme_datapath #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          capture,
    input  logic [sme_pkg::OP_W-1:0]      op,
    input  logic [sme_pkg::DATA_W-1:0]    operand,
    input  sme_pkg::sme_cmd_t             cmd,
    output sme_pkg::sme_stat_t            stat,
    output logic [sme_pkg::OP_W-1:0]      op_q,
    output logic [sme_pkg::DATA_W-1:0]    data,
    output logic [sme_pkg::STATUS_W-1:0]  status,
    output logic [sme_pkg::DEPTH_W-1:0]   depth,
    output logic                          last,
    output logic                          valid
);
    import sme_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] opd_reg;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     dptr_reg;
    logic [DATA_W-1:0] a_reg, b_reg, res_reg, top_reg;
    logic [DATA_W-1:0] rdata;
    logic [AW-1:0]     raddr, waddr;
    logic [DATA_W-1:0] wdata;
    logic [CW-1:0]     top_idx, next_idx;
    logic [DATA_W-1:0] quo, rem;
    logic [DATA_W-1:0] data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic              last_reg, valid_reg;

    assign top_idx  = cnt_reg - 1'b1;
    assign next_idx = cnt_reg - CW'(2);

    always_comb
    begin
        case (cmd.raddr_sel)
            RA_TOP:  raddr = top_idx[AW-1:0];
            RA_NEXT: raddr = next_idx[AW-1:0];
            RA_DUMP: raddr = dptr_reg[AW-1:0];
            default: raddr = top_idx[AW-1:0];
        endcase
        case (cmd.waddr_sel)
            WA_COUNT: waddr = cnt_reg[AW-1:0];
            WA_TOP:   waddr = top_idx[AW-1:0];
            WA_NEXT:  waddr = next_idx[AW-1:0];
            default:  waddr = cnt_reg[AW-1:0];
        endcase
        case (cmd.wdata_sel)
            WD_OPERAND: wdata = opd_reg;
            WD_A:       wdata = a_reg;
            WD_B:       wdata = b_reg;
            WD_RESULT:  wdata = res_reg;
            default:    wdata = opd_reg;
        endcase
    end

    sme_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    sme_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (cmd.div_go),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .done      (stat.div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            op_reg  <= op;
            opd_reg <= operand;
        end
        if (cmd.dump_load)
        begin
            dptr_reg <= top_idx;
        end
        else if (cmd.dump_dec)
        begin
            dptr_reg <= dptr_reg - 1'b1;
        end
        if (cmd.ld_a)
        begin
            a_reg <= rdata;
        end
        if (cmd.ld_b)
        begin
            b_reg <= rdata;
        end
        if (cmd.ld_top)
        begin
            top_reg <= rdata;
        end
        if (cmd.alu_go)
        begin
            case (op_reg)
                OP_ADD:  res_reg <= a_reg + b_reg;
                OP_SUB:  res_reg <= a_reg - b_reg;
                OP_MUL:  res_reg <= a_reg * b_reg;
                OP_DIV:  res_reg <= quo;
                OP_MOD:  res_reg <= rem;
                default: res_reg <= a_reg;
            endcase
        end
        if (cmd.emit)
        begin
            case (cmd.rsel)
                RS_TOP:  data_reg <= top_reg;
                RS_DUMP: data_reg <= rdata;
                RS_ZERO: data_reg <= '0;
                default: data_reg <= '0;
            endcase
            status_reg <= cmd.status;
            depth_reg  <= DEPTH_W'(cnt_reg);
            last_reg   <= cmd.last;
        end
    end

    assign stat.empty     = (cnt_reg == '0);
    assign stat.one       = (cnt_reg == CW'(1));
    assign stat.full      = (cnt_reg == CW'(STACK_DEPTH));
    assign stat.dump_last = (dptr_reg == '0);
    assign stat.b_zero    = (b_reg == '0);
    assign stat.div_ovf   = (a_reg == {1'b1, {(DATA_W-1){1'b0}}}) && (b_reg == '1);
    assign stat.assert_eq = (a_reg == opd_reg);

    assign op_q   = op_reg;
    assign data   = data_reg;
    assign status = status_reg;
    assign depth  = depth_reg;
    assign last   = last_reg;
    assign valid  = valid_reg;

endmodule

// ----- rtl/sme_ctrl.sv -----
// ----------------------------------------------------------------------------
// sme_ctrl
// Command sequencer: decodes one op and steps the datapath through it.
// ----------------------------------------------------------------------------
module sme_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sme_pkg::OP_W-1:0]  op_q,
    input  sme_pkg::sme_stat_t        stat,
    output logic                      busy,
    output logic                      capture,
    output sme_pkg::sme_cmd_t         cmd
);
    import sme_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_A,
        S_RD_B,
        S_CHECK,
        S_DIV,
        S_ALU,
        S_WRITE,
        S_RD_TOP,
        S_TOP_WAIT,
        S_REPORT,
        S_DUMP_RD,
        S_DUMP_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] st_reg, st_next;

    assign capture = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.raddr_sel = RA_TOP;
        cmd.waddr_sel = WA_COUNT;
        cmd.wdata_sel = WD_OPERAND;
        cmd.rsel      = RS_TOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                st_next    = ST_OK;
                state_next = S_RD_TOP;
                case (op_q)
                    OP_PUSH:
                    begin
                        if (stat.full)
                        begin
                            st_next = ST_OVER;
                        end
                        else
                        begin
                            cmd.we      = 1'b1;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    OP_POP:
                    begin
                        if (stat.empty)
                        begin
                            st_next = ST_UNDER;
                        end
                        else
                        begin
                            cmd.cnt_dec = 1'b1;
                        end
                    end
                    OP_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.rsel   = RS_ZERO;
                            cmd.status = ST_UNDER;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.dump_load = 1'b1;
                            state_next    = S_DUMP_RD;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.cnt_clr = 1'b1;
                    end
                    OP_DUP, OP_ASSERT:
                    begin
                        if (stat.empty)
                        begin
                            st_next = ST_UNDER;
                        end
                        else if (op_q == OP_DUP && stat.full)
                        begin
                            st_next = ST_OVER;
                        end
                        else
                        begin
                            state_next = S_RD_A;
                        end
                    end
                    OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                    begin
                        if (stat.empty || stat.one)
                        begin
                            st_next = ST_UNDER;
                        end
                        else
                        begin
                            state_next = S_RD_A;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RD_A:
            begin
                cmd.raddr_sel = RA_TOP;
                state_next    = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.ld_a      = 1'b1;
                cmd.raddr_sel = RA_NEXT;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.ld_b   = 1'b1;
                state_next = S_ALU;
            end
            S_ALU:
            begin
                state_next = S_RD_TOP;
                case (op_q)
                    OP_DUP:
                    begin
                        cmd.we        = 1'b1;
                        cmd.waddr_sel = WA_COUNT;
                        cmd.wdata_sel = WD_A;
                        cmd.cnt_inc   = 1'b1;
                    end
                    OP_ASSERT:
                    begin
                        if (!stat.assert_eq)
                        begin
                            st_next = ST_ASSERT;
                        end
                    end
                    OP_SWAP:
                    begin
                        cmd.we        = 1'b1;
                        cmd.waddr_sel = WA_TOP;
                        cmd.wdata_sel = WD_B;
                        state_next    = S_WRITE;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (stat.b_zero)
                        begin
                            st_next = ST_DIVZERO;
                        end
                        else if (op_q == OP_DIV && stat.div_ovf)
                        begin
                            st_next = ST_OVER;
                        end
                        else
                        begin
                            cmd.div_go = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        cmd.alu_go = 1'b1;
                        state_next = S_WRITE;
                    end
                endcase
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.alu_go = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.we        = 1'b1;
                cmd.waddr_sel = WA_NEXT;
                if (op_q == OP_SWAP)
                begin
                    cmd.wdata_sel = WD_A;
                end
                else
                begin
                    cmd.wdata_sel = WD_RESULT;
                    cmd.cnt_dec   = 1'b1;
                end
                state_next = S_RD_TOP;
            end
            S_RD_TOP:
            begin
                cmd.raddr_sel = RA_TOP;
                state_next    = S_TOP_WAIT;
            end
            S_TOP_WAIT:
            begin
                cmd.ld_top = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                cmd.emit   = 1'b1;
                cmd.rsel   = stat.empty ? RS_ZERO : RS_TOP;
                cmd.status = st_reg;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
            end
            S_DUMP_RD:
            begin
                cmd.raddr_sel = RA_DUMP;
                state_next    = S_DUMP_EMIT;
            end
            S_DUMP_EMIT:
            begin
                cmd.emit   = 1'b1;
                cmd.rsel   = RS_DUMP;
                cmd.status = ST_OK;
                cmd.last   = stat.dump_last;
                if (stat.dump_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.dump_dec = 1'b1;
                    state_next   = S_DUMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule

// ----- rtl/stack_machine_executor.sv -----
// ----------------------------------------------------------------------------
// stack_machine_executor
// Signed 32-bit stack machine: one command per start, results on a strobe.
// ----------------------------------------------------------------------------
// Push/pop/clear/unused ops and early errors go from decode to the report;
// dup/assert and div/mod errors first read operands, swap/add/sub/mul add a
// write-back, div/mod also wait on the serial divider. Dump reports underflow
// when empty, else emits from the top down via the single registered read port.
// busy drops with the final strobe, so the next start can follow it; results
// cannot be stalled. Reset empties the stack; RAM contents are not cleared.
module stack_machine_executor #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sme_pkg::OP_W-1:0]      op,
    input  logic signed [sme_pkg::DATA_W-1:0] operand,
    output logic                          strobe,
    output logic signed [sme_pkg::DATA_W-1:0] data,
    output logic [sme_pkg::STATUS_W-1:0]  status,
    output logic [sme_pkg::DEPTH_W-1:0]   depth,
    output logic                          last
);
    import sme_pkg::*;

    sme_cmd_t        cmd;
    sme_stat_t       stat;
    logic            capture;
    logic [OP_W-1:0] op_q;

    sme_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .op_q    (op_q),
        .stat    (stat),
        .busy    (busy),
        .capture (capture),
        .cmd     (cmd)
    );

    sme_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (capture),
        .op      (op),
        .operand (operand),
        .cmd     (cmd),
        .stat    (stat),
        .op_q    (op_q),
        .data    (data),
        .status  (status),
        .depth   (depth),
        .last    (last),
        .valid   (strobe)
    );

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (depth <= DEPTH_W'(STACK_DEPTH)))
        else $error("depth beyond stack size");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("strobe after last");

    a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status == ST_ASSERT || status == ST_DIVZERO)) |-> last)
        else $error("error result not final");

endmodule
